FILE: src/slle_pkg.sv
// Shared types and constants for the static linked list engine.
// No dependencies; imported by every module of the block.
package slle_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int POS_W          = 5;
  localparam int VAL_W          = 32;
  localparam int LEN_W          = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_GRAB,
    S_WALK,
    S_INS_A,
    S_INS_B,
    S_REM_A,
    S_REM_B,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic next_we;
    logic value_we;
  } mem_wr_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   value;
  } result_t;

endpackage

FILE: src/slle_mem.sv
// Slot storage: link array and value array, one write and one registered read port each.
// Runs the link-array initialization sweep after reset. Depends on slle_pkg.
module slle_mem import slle_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int AW = $clog2(CAPACITY),
  localparam int PW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [AW-1:0]         raddr,
  input  mem_wr_t               wr,
  input  logic [AW-1:0]         waddr,
  input  logic [PW-1:0]         next_wdata,
  input  logic [DATA_WIDTH-1:0] value_wdata,
  output logic [PW-1:0]         rd_next,
  output logic [DATA_WIDTH-1:0] rd_value,
  output logic                  busy
);

  logic [PW-1:0]         next_mem  [CAPACITY];
  logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
  logic                  clearing;
  logic [AW-1:0]         clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(CAPACITY - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      next_mem[clr_idx] <= PW'(clr_idx) + PW'(1);
    end else if (wr.next_we) begin
      next_mem[waddr] <= next_wdata;
    end
    rd_next <= next_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.value_we) begin
      value_mem[waddr] <= value_wdata;
    end
    rd_value <= value_mem[raddr];
  end

  assign busy = clearing;

endmodule

FILE: src/slle_ctrl.sv
// Request sequencer: range and capacity checks, link walk through the shared memory read port,
// and the insert/remove link updates. Depends on slle_pkg.
module slle_ctrl import slle_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int AW   = $clog2(CAPACITY),
  localparam int PW   = $clog2(CAPACITY + 1),
  localparam int CW   = $clog2(CAPACITY + 1),
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  logic [POS_W-1:0]      position,
  input  logic [VAL_W-1:0]      value_in,
  input  logic                  busy,
  input  logic [PW-1:0]         rd_next,
  input  logic [DATA_WIDTH-1:0] rd_value,
  output logic [AW-1:0]         raddr,
  output mem_wr_t               wr,
  output logic [AW-1:0]         waddr,
  output logic [PW-1:0]         next_wdata,
  output logic [DATA_WIDTH-1:0] value_wdata,
  output logic                  res_valid,
  output result_t               res,
  output logic [LEN_W-1:0]      len,
  input  logic                  out_free
);

  state_t                state, state_next;
  logic [1:0]            op;
  logic [POS_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] val;
  logic [PW-1:0]         list_head, free_head, fnext, n0, n1, node;
  logic [CW-1:0]         count;
  logic [POS_W-1:0]      hops;
  logic                  first;
  status_t               res_status, chk_status;
  logic [VAL_W-1:0]      res_value;
  logic                  pos1, ins_bad, acc_bad, full;
  logic [CMPW-1:0]       pos_x, cnt_x;

  function automatic logic [VAL_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
    return VAL_W'($signed(v));
  endfunction

  assign pos1  = (pos == POS_W'(1));
  assign pos_x = CMPW'(pos);
  assign cnt_x = CMPW'(count);
  assign ins_bad = (pos == '0) || (pos_x > cnt_x + CMPW'(1));
  assign acc_bad = (pos == '0) || (pos_x > cnt_x);
  assign full    = (count == CW'(CAPACITY)) || (free_head >= PW'(CAPACITY));
  assign node    = first ? list_head : rd_next;

  always_comb begin
    case (op)
      OP_INSERT: chk_status = ins_bad ? ST_RANGE : (full ? ST_FULL : ST_OK);
      OP_REMOVE, OP_READ: chk_status = acc_bad ? ST_RANGE : ST_OK;
      default: chk_status = ST_RANGE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    raddr       = node[AW-1:0];
    wr          = '0;
    waddr       = free_head[AW-1:0];
    next_wdata  = rd_next;
    value_wdata = val;
    case (state)
      S_IDLE: begin
        in_ready = !busy;
        if (in_valid && !busy) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_status != ST_OK) begin
          state_next = S_DONE;
        end else if (op == OP_INSERT) begin
          state_next = S_ALLOC;
        end else begin
          state_next = S_WALK;
        end
      end
      S_ALLOC: begin
        raddr      = free_head[AW-1:0];
        state_next = S_GRAB;
      end
      S_GRAB: begin
        state_next = pos1 ? S_INS_A : S_WALK;
      end
      S_WALK: begin
        if (hops == POS_W'(1)) begin
          case (op)
            OP_INSERT: state_next = S_INS_A;
            OP_REMOVE: state_next = S_REM_A;
            default:   state_next = S_READ;
          endcase
        end
      end
      S_INS_A: begin
        wr.next_we  = 1'b1;
        wr.value_we = 1'b1;
        next_wdata  = pos1 ? list_head : rd_next;
        state_next  = S_INS_B;
      end
      S_INS_B: begin
        wr.next_we = !pos1;
        waddr      = n1[AW-1:0];
        next_wdata = free_head;
        state_next = S_DONE;
      end
      S_REM_A: begin
        wr.next_we = !pos1;
        waddr      = n0[AW-1:0];
        next_wdata = rd_next;
        state_next = S_REM_B;
      end
      S_REM_B: begin
        wr.next_we = 1'b1;
        waddr      = n1[AW-1:0];
        next_wdata = free_head;
        state_next = S_DONE;
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= PW'(CAPACITY);
      free_head <= '0;
      count     <= '0;
    end else begin
      case (state)
        S_INS_B: begin
          if (pos1) begin
            list_head <= free_head;
          end
          free_head <= fnext;
          count     <= count + CW'(1);
        end
        S_REM_A: begin
          if (pos1) begin
            list_head <= rd_next;
          end
        end
        S_REM_B: begin
          free_head <= n1;
          count     <= count - CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op  <= opcode;
        pos <= position;
        val <= DATA_WIDTH'($unsigned(value_in));
      end
      S_CHECK: begin
        res_status <= chk_status;
        res_value  <= '0;
        first      <= 1'b1;
        hops       <= pos;
      end
      S_GRAB: begin
        fnext <= rd_next;
        first <= 1'b1;
        hops  <= pos - POS_W'(1);
      end
      S_WALK: begin
        n0    <= n1;
        n1    <= node;
        first <= 1'b0;
        hops  <= hops - POS_W'(1);
      end
      S_INS_B: res_value <= widen(val);
      S_REM_A: res_value <= widen(rd_value);
      S_READ:  res_value <= widen(rd_value);
      default: ;
    endcase
  end

  assign res.status = res_status;
  assign res.value  = res_value;
  assign len        = LEN_W'(count);

endmodule

FILE: src/static_linked_list_engine_core.sv
// Static linked list engine, top level: sequencer, slot storage and result register.
// Depends on slle_pkg, slle_mem and slle_ctrl.
//
// Array-backed singly linked list of CAPACITY slots with a free list. One request at a
// time; in_ready is high only while the sequencer is idle. Every hop of the walk is one
// read of the link memory, so the time a request takes grows with its position; a
// rejected request skips the walk. A finished result sits in the output register and
// the next request is accepted while it waits. After reset the link memory is swept
// once, slot by slot, and no request is accepted during the sweep.
module static_linked_list_engine_core import slle_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] value_out,
  output logic [LEN_W-1:0]        length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  logic [AW-1:0]         raddr, waddr;
  mem_wr_t               wr;
  logic [PW-1:0]         next_wdata, rd_next;
  logic [DATA_WIDTH-1:0] value_wdata, rd_value;
  logic                  busy, res_valid, out_free;
  result_t               res;
  logic [LEN_W-1:0]      len;

  slle_mem #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk         (clk),
    .rst         (rst),
    .raddr       (raddr),
    .wr          (wr),
    .waddr       (waddr),
    .next_wdata  (next_wdata),
    .value_wdata (value_wdata),
    .rd_next     (rd_next),
    .rd_value    (rd_value),
    .busy        (busy)
  );

  slle_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .position    (position),
    .value_in    (value_in),
    .busy        (busy),
    .rd_next     (rd_next),
    .rd_value    (rd_value),
    .raddr       (raddr),
    .wr          (wr),
    .waddr       (waddr),
    .next_wdata  (next_wdata),
    .value_wdata (value_wdata),
    .res_valid   (res_valid),
    .res         (res),
    .len         (len),
    .out_free    (out_free)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      status    <= res.status;
      value_out <= res.value;
      length    <= len;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while sequencer busy");

  a_error_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> value_out == '0)
    else $error("rejected transaction carries a nonzero value");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> length == LEN_W'(CAPACITY))
    else $error("list full reported below capacity");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("request accepted during link memory sweep");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for static_linked_list_engine_core: directed table, then random mixes.
// Expected results come from a queue-based list model kept in step with each accepted request.
// Depends on slle_pkg and the RTL under src.
`timescale 1ns / 100ps

module testbench;
  import slle_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 50;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_STEPS = 22;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] len;
  } outcome_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    outcome_t         want;
  } step_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              opcode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value_in;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] value_out;
  logic [LEN_W-1:0]        length;

  logic [VAL_W-1:0] list_contents[$];
  outcome_t         expected_results[$];
  step_t            directed_steps[NUM_STEPS];

  int  send_idle;
  int  stall_pct;
  bit  hold_req;
  int  hold_count;
  int  cycle_count;
  int  errors;
  int  sent_count;
  int  checked_count;
  int  ok_count;
  int  range_count;
  int  full_count;
  int  peak_len;

  static_linked_list_engine_core #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DEF_DATA_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .position (position),
    .value_in (value_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .value_out(value_out),
    .length   (length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, what, got, want);
    end
  endtask

  function automatic outcome_t predict_outcome(input logic [1:0] op,
                                               input logic [POS_W-1:0] pos,
                                               input logic [VAL_W-1:0] val);
    outcome_t res;
    int       p;
    int       n;
    p = int'(pos);
    n = list_contents.size();
    res.status = ST_OK;
    res.value = '0;
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > n + 1) begin
          res.status = ST_RANGE;
        end else if (n >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_contents.insert(p - 1, val);
          res.value = val;
        end
      end
      OP_REMOVE: begin
        if (p < 1 || p > n) begin
          res.status = ST_RANGE;
        end else begin
          res.value = list_contents[p - 1];
          list_contents.delete(p - 1);
        end
      end
      OP_READ: begin
        if (p < 1 || p > n) begin
          res.status = ST_RANGE;
        end else begin
          res.value = list_contents[p - 1];
        end
      end
      default: res.status = ST_RANGE;
    endcase
    res.len = LEN_W'(list_contents.size());
    if (list_contents.size() > peak_len) peak_len = list_contents.size();
    return res;
  endfunction

  // Start and end on a falling edge; hold the transaction until accepted.
  task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val, input logic typed,
                              input outcome_t typed_want);
    outcome_t predicted;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    position <= pos;
    value_in <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_outcome(op, pos, val);
    expected_results.push_back(typed ? typed_want : predicted);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_random(input int insert_bias);
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               n;
    int               r;
    n = list_contents.size();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      op  = 2'($urandom_range(0, 3));
      pos = POS_W'($urandom_range(0, 31));
    end else begin
      r = $urandom_range(0, 99);
      if (r < insert_bias) op = OP_INSERT;
      else if (r < insert_bias + (100 - insert_bias) / 2) op = OP_REMOVE;
      else op = OP_READ;
      if (op == OP_INSERT) pos = POS_W'($urandom_range(1, n + 1));
      else pos = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
    end
    case ($urandom_range(0, 9))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = 32'hffff_ffff;
      3: val = 32'h0000_0000;
      default: val = $urandom;
    endcase
    send_request(op, pos, val, 1'b0, '0);
  endtask

  task automatic check_result();
    outcome_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch("transaction with nothing pending", value_out, '0);
    end else begin
      want = expected_results.pop_front();
      checked_count++;
      if (want.status == ST_OK) ok_count++;
      else if (want.status == ST_FULL) full_count++;
      else range_count++;
      if (status !== want.status) flag_mismatch("status", 32'(status), 32'(want.status));
      if (value_out !== want.value) flag_mismatch("value_out", value_out, want.value);
      if (length !== want.len) flag_mismatch("length", 32'(length), 32'(want.len));
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_valid && out_ready) check_result();
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_count == 0) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_count += HOLD_CYCLES;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    int ph;
    int i;
    int bias;
    rst      = 1'b1;
    in_valid = 1'b0;
    opcode   = OP_INSERT;
    position = '0;
    value_in = '0;
    send_idle = 0;
    stall_pct = 0;
    hold_req  = 1'b0;

    directed_steps = '{
      '{OP_READ,   5'd1,  32'hdead_beef, 1'b1, '{ST_RANGE, 32'h0, 5'd0}},
      '{OP_REMOVE, 5'd0,  32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 5'd0}},
      '{OP_INSERT, 5'd0,  32'h0000_0005, 1'b1, '{ST_RANGE, 32'h0, 5'd0}},
      '{OP_INSERT, 5'd2,  32'h0000_0005, 1'b1, '{ST_RANGE, 32'h0, 5'd0}},
      '{OP_UNUSED, 5'd1,  32'h1234_5678, 1'b1, '{ST_RANGE, 32'h0, 5'd0}},
      '{OP_INSERT, 5'd1,  32'h8000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 5'd1}},
      '{OP_INSERT, 5'd2,  32'h7fff_ffff, 1'b1, '{ST_OK, 32'h7fff_ffff, 5'd2}},
      '{OP_INSERT, 5'd1,  32'hffff_ffff, 1'b1, '{ST_OK, 32'hffff_ffff, 5'd3}},
      '{OP_INSERT, 5'd31, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 5'd3}},
      '{OP_READ,   5'd31, 32'hffff_ffff, 1'b1, '{ST_RANGE, 32'h0, 5'd3}},
      '{OP_INSERT, 5'd3,  32'h1234_5678, 1'b0, '0},
      '{OP_READ,   5'd1,  32'hdead_beef, 1'b0, '0},
      '{OP_READ,   5'd4,  32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE, 5'd5,  32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0, 5'd4}},
      '{OP_REMOVE, 5'd2,  32'hdead_beef, 1'b0, '0},
      '{OP_REMOVE, 5'd3,  32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE, 5'd1,  32'h0000_0000, 1'b0, '0},
      '{OP_UNUSED, 5'd0,  32'hffff_ffff, 1'b1, '{ST_RANGE, 32'h0, 5'd1}},
      '{OP_READ,   5'd1,  32'h0000_0000, 1'b0, '0},
      '{OP_REMOVE, 5'd1,  32'h0000_0000, 1'b0, '0},
      '{OP_INSERT, 5'd1,  32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 5'd1}},
      '{OP_REMOVE, 5'd1,  32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 5'd0}}
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_STEPS; i++) begin
      send_request(directed_steps[i].op, directed_steps[i].pos, directed_steps[i].val,
                   directed_steps[i].typed, directed_steps[i].want);
    end

    // Each phase fills the list past full, mixes, then drains below empty.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 50; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 50; end
        default: begin send_idle = 31; stall_pct = 31; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 20) hold_req = 1'b1;
        bias = (i < 40) ? 85 : (i < 70) ? 50 : 10;
        send_random(bias);
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_mismatch("results left pending", expected_results.size(), '0);
    end

    $display("Checked %0d of %0d requests: %0d ok, %0d out of range, %0d list full.",
             checked_count, sent_count, ok_count, range_count, full_count);
    $display("Peak length %0d; output held off %0d cycles while requests kept coming.",
             peak_len, hold_count);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
